[rtl/segta_pkg.sv]
`timescale 1ns / 1ps

package segta_pkg;

	localparam int DEF_CORDIC_STEPS = 16;
	localparam int DEF_COORD_WIDTH  = 32;

	// Width of every coordinate field on the input channel
	localparam int FIELD_W = 32;
	// Result angle, binary units with pi = 32768
	localparam int ANGLE_W = 17;
	// Heading accumulator: quarter-turn pre-rotation plus the arctangent sum stays below 2^16
	localparam int Z_W     = 17;
	// Difference of two headings before wrapping
	localparam int DIFF_W  = 18;

	localparam int HALF_TURN    = 32768;
	localparam int FULL_TURN    = 65536;
	localparam int QUARTER_TURN = 16384;

	localparam int MAX_STEPS = 32;

	// atan(2^-i) in binary angle units, rounded
	localparam logic [15:0] ATAN_UNITS [MAX_STEPS] = '{
		16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
		16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
		16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0,
		16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
	};

	typedef struct packed {
		logic valid;
		logic undef;
	} segta_ctl_t;

endpackage

[rtl/segta_if.sv]
`timescale 1ns / 1ps

interface segta_seg_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [segta_pkg::FIELD_W-1:0] from_start_x;
	logic signed [segta_pkg::FIELD_W-1:0] from_start_y;
	logic signed [segta_pkg::FIELD_W-1:0] from_end_x;
	logic signed [segta_pkg::FIELD_W-1:0] from_end_y;
	logic                                 from_toward_node;
	logic signed [segta_pkg::FIELD_W-1:0] to_start_x;
	logic signed [segta_pkg::FIELD_W-1:0] to_start_y;
	logic signed [segta_pkg::FIELD_W-1:0] to_end_x;
	logic signed [segta_pkg::FIELD_W-1:0] to_end_y;
	logic                                 to_away_reversed;

	modport source (
		output valid, from_start_x, from_start_y, from_end_x, from_end_y, from_toward_node,
		output to_start_x, to_start_y, to_end_x, to_end_y, to_away_reversed,
		input  ready
	);
	modport sink (
		input  valid, from_start_x, from_start_y, from_end_x, from_end_y, from_toward_node,
		input  to_start_x, to_start_y, to_end_x, to_end_y, to_away_reversed,
		output ready
	);
endinterface

interface segta_turn_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [segta_pkg::ANGLE_W-1:0] turn_angle;
	logic                                 angle_undefined;

	modport source (
		output valid, turn_angle, angle_undefined,
		input  ready
	);
	modport sink (
		input  valid, turn_angle, angle_undefined,
		output ready
	);
endinterface

[rtl/segta_prep.sv]
`timescale 1ns / 1ps

module segta_prep #(
	parameter int COORD_WIDTH = segta_pkg::DEF_COORD_WIDTH,
	parameter int XW          = segta_pkg::DEF_COORD_WIDTH + 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	segta_seg_if.sink                         segs,
	output segta_pkg::segta_ctl_t             ctl,
	output logic signed [XW-1:0]              fx,
	output logic signed [XW-1:0]              fy,
	output logic signed [segta_pkg::Z_W-1:0]  fz,
	output logic signed [XW-1:0]              tx,
	output logic signed [XW-1:0]              ty,
	output logic signed [segta_pkg::Z_W-1:0]  tz
);
	import segta_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	logic                   valid_s1;
	logic signed [DW-1:0]   fdx_s1, fdy_s1, tdx_s1, tdy_s1;
	logic                   frev_s1, trev_s1;

	segta_ctl_t             ctl_s2;
	logic signed [XW-1:0]   fx_s2, fy_s2, tx_s2, ty_s2;
	logic signed [Z_W-1:0]  fz_s2, tz_s2;

	logic signed [XW-1:0]   fx_d, fy_d, tx_d, ty_d;
	logic signed [Z_W-1:0]  fz_d, tz_d;
	logic                   undef_d;

	function automatic logic signed [DW-1:0] seg_delta(
		input logic signed [FIELD_W-1:0] p_end,
		input logic signed [FIELD_W-1:0] p_start
	);
		logic signed [COORD_WIDTH-1:0] e, s;
		e = COORD_WIDTH'(p_end);
		s = COORD_WIDTH'(p_start);
		return DW'(e) - DW'(s);
	endfunction

	// Quarter-turn pre-rotation into the right half plane; segment reversal folded in,
	// so the x and y outputs are each a single signed copy of dx or dy.
	function automatic void prerot(
		input  logic signed [DW-1:0]  dx,
		input  logic signed [DW-1:0]  dy,
		input  logic                  rev,
		output logic signed [XW-1:0]  x,
		output logic signed [XW-1:0]  y,
		output logic signed [Z_W-1:0] z
	);
		logic                 negx, ypos;
		logic signed [XW-1:0] ex, ey;
		ex   = XW'(dx);
		ey   = XW'(dy);
		negx = rev ? (!dx[DW-1] && dx != '0) : dx[DW-1];
		ypos = rev ? (dy[DW-1] || dy == '0) : !dy[DW-1];
		if (!negx) begin
			x = rev ? -ex : ex;
			y = rev ? -ey : ey;
			z = '0;
		end else if (ypos) begin
			x = rev ? -ey : ey;
			y = rev ? ex : -ex;
			z = Z_W'(QUARTER_TURN);
		end else begin
			x = rev ? ey : -ey;
			y = rev ? -ex : ex;
			z = -Z_W'(QUARTER_TURN);
		end
	endfunction

	assign segs.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= segs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fdx_s1  <= seg_delta(segs.from_end_x, segs.from_start_x);
			fdy_s1  <= seg_delta(segs.from_end_y, segs.from_start_y);
			tdx_s1  <= seg_delta(segs.to_end_x, segs.to_start_x);
			tdy_s1  <= seg_delta(segs.to_end_y, segs.to_start_y);
			frev_s1 <= segs.from_toward_node;
			trev_s1 <= segs.to_away_reversed;
		end
	end

	always_comb begin
		prerot(fdx_s1, fdy_s1, frev_s1, fx_d, fy_d, fz_d);
		prerot(tdx_s1, tdy_s1, trev_s1, tx_d, ty_d, tz_d);
		undef_d = (fdx_s1 == '0 && fdy_s1 == '0) || (tdx_s1 == '0 && tdy_s1 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= '{valid: valid_s1, undef: undef_d};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s2        <= fx_d;
			fy_s2        <= fy_d;
			fz_s2        <= fz_d;
			tx_s2        <= tx_d;
			ty_s2        <= ty_d;
			tz_s2        <= tz_d;
		end
	end

	assign ctl = ctl_s2;
	assign fx  = fx_s2;
	assign fy  = fy_s2;
	assign fz  = fz_s2;
	assign tx  = tx_s2;
	assign ty  = ty_s2;
	assign tz  = tz_s2;

endmodule

[rtl/segta_cell.sv]
`timescale 1ns / 1ps

module segta_cell #(
	parameter int XW   = segta_pkg::DEF_COORD_WIDTH + 3,
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  segta_pkg::segta_ctl_t             ctl_in,
	input  logic signed [XW-1:0]              fx_in,
	input  logic signed [XW-1:0]              fy_in,
	input  logic signed [segta_pkg::Z_W-1:0]  fz_in,
	input  logic signed [XW-1:0]              tx_in,
	input  logic signed [XW-1:0]              ty_in,
	input  logic signed [segta_pkg::Z_W-1:0]  tz_in,
	output segta_pkg::segta_ctl_t             ctl_out,
	output logic signed [XW-1:0]              fx_out,
	output logic signed [XW-1:0]              fy_out,
	output logic signed [segta_pkg::Z_W-1:0]  fz_out,
	output logic signed [XW-1:0]              tx_out,
	output logic signed [XW-1:0]              ty_out,
	output logic signed [segta_pkg::Z_W-1:0]  tz_out
);
	import segta_pkg::*;

	localparam logic signed [Z_W-1:0] DZ = Z_W'(ATAN_UNITS[STEP]);

	segta_ctl_t             ctl_s1;
	logic signed [XW-1:0]   fx_s1, fy_s1, tx_s1, ty_s1;
	logic signed [Z_W-1:0]  fz_s1, tz_s1;

	logic signed [XW-1:0]   fx_d, fy_d, tx_d, ty_d;
	logic signed [Z_W-1:0]  fz_d, tz_d;

	// One vectoring micro-rotation; shifts floor toward minus infinity
	function automatic void rotate(
		input  logic signed [XW-1:0]  x,
		input  logic signed [XW-1:0]  y,
		input  logic signed [Z_W-1:0] z,
		output logic signed [XW-1:0]  xn,
		output logic signed [XW-1:0]  yn,
		output logic signed [Z_W-1:0] zn
	);
		logic signed [XW-1:0] xs, ys;
		xs = x >>> STEP;
		ys = y >>> STEP;
		if (y[XW-1]) begin
			xn = x - ys;
			yn = y + xs;
			zn = z - DZ;
		end else begin
			xn = x + ys;
			yn = y - xs;
			zn = z + DZ;
		end
	endfunction

	always_comb begin
		rotate(fx_in, fy_in, fz_in, fx_d, fy_d, fz_d);
		rotate(tx_in, ty_in, tz_in, tx_d, ty_d, tz_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1        <= fx_d;
			fy_s1        <= fy_d;
			fz_s1        <= fz_d;
			tx_s1        <= tx_d;
			ty_s1        <= ty_d;
			tz_s1        <= tz_d;
		end
	end

	assign ctl_out = ctl_s1;
	assign fx_out  = fx_s1;
	assign fy_out  = fy_s1;
	assign fz_out  = fz_s1;
	assign tx_out  = tx_s1;
	assign ty_out  = ty_s1;
	assign tz_out  = tz_s1;

endmodule

[rtl/segta_wrap.sv]
`timescale 1ns / 1ps

module segta_wrap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  segta_pkg::segta_ctl_t             ctl,
	input  logic signed [segta_pkg::Z_W-1:0]  fz,
	input  logic signed [segta_pkg::Z_W-1:0]  tz,
	output logic                              en,
	segta_turn_if.source                      turn
);
	import segta_pkg::*;

	localparam logic signed [DIFF_W-1:0] HALF_D = DIFF_W'(HALF_TURN);
	localparam logic signed [DIFF_W-1:0] FULL_D = DIFF_W'(FULL_TURN);

	logic                       valid_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic                       undef_q;

	logic signed [DIFF_W-1:0]   diff, wrapped;

	always_comb begin
		diff = DIFF_W'(fz) - DIFF_W'(tz);
		if (diff > HALF_D) begin
			wrapped = diff - FULL_D;
		end else if (diff < -HALF_D) begin
			wrapped = diff + FULL_D;
		end else begin
			wrapped = diff;
		end
	end

	// whole chain advances unless a finished beat is held at the output
	assign en = !valid_q || turn.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			undef_q <= ctl.undef;
			angle_q <= ctl.undef ? '0 : ANGLE_W'(wrapped);
		end
	end

	assign turn.valid           = valid_q;
	assign turn.turn_angle      = angle_q;
	assign turn.angle_undefined = undef_q;

endmodule

[rtl/segment_turn_angle_core.sv]
`timescale 1ns / 1ps
// Pipeline from input beat to output beat: two preparation stages, one stage per
//   CORDIC cell, one wrap/output stage.
// Throughput: one beat per cycle; the cell chain stalls as a whole only while the
//   output register holds a beat that has not been taken.
// Reset: arst_n clears all valid bits asynchronously; datapath registers are not reset.
module segment_turn_angle_core #(
	parameter int CORDIC_STEPS = segta_pkg::DEF_CORDIC_STEPS,
	parameter int COORD_WIDTH  = segta_pkg::DEF_COORD_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	segta_seg_if.sink    segs,
	segta_turn_if.source turn
);
	import segta_pkg::*;

	// dx/dy take one extra bit, CORDIC gain and pre-rotation two more
	localparam int XW = COORD_WIDTH + 3;

	logic                   en;
	segta_ctl_t             ctl_c [CORDIC_STEPS+1];
	logic signed [XW-1:0]   fx_c  [CORDIC_STEPS+1];
	logic signed [XW-1:0]   fy_c  [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  fz_c  [CORDIC_STEPS+1];
	logic signed [XW-1:0]   tx_c  [CORDIC_STEPS+1];
	logic signed [XW-1:0]   ty_c  [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  tz_c  [CORDIC_STEPS+1];

	segta_prep #(
		.COORD_WIDTH(COORD_WIDTH),
		.XW         (XW)
	) u_prep (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.segs  (segs),
		.ctl   (ctl_c[0]),
		.fx    (fx_c[0]),
		.fy    (fy_c[0]),
		.fz    (fz_c[0]),
		.tx    (tx_c[0]),
		.ty    (ty_c[0]),
		.tz    (tz_c[0])
	);

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		segta_cell #(
			.XW  (XW),
			.STEP(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_c[i]),
			.fx_in  (fx_c[i]),
			.fy_in  (fy_c[i]),
			.fz_in  (fz_c[i]),
			.tx_in  (tx_c[i]),
			.ty_in  (ty_c[i]),
			.tz_in  (tz_c[i]),
			.ctl_out(ctl_c[i+1]),
			.fx_out (fx_c[i+1]),
			.fy_out (fy_c[i+1]),
			.fz_out (fz_c[i+1]),
			.tx_out (tx_c[i+1]),
			.ty_out (ty_c[i+1]),
			.tz_out (tz_c[i+1])
		);
	end

	segta_wrap u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl_c[CORDIC_STEPS]),
		.fz    (fz_c[CORDIC_STEPS]),
		.tz    (tz_c[CORDIC_STEPS]),
		.en    (en),
		.turn  (turn)
	);

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		turn.valid && turn.angle_undefined |-> turn.turn_angle == '0)
		else $error("undefined turn carries a nonzero angle");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		turn.valid |-> (turn.turn_angle >= -HALF_TURN && turn.turn_angle <= HALF_TURN))
		else $error("turn angle outside half-turn range");

	a_chain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(ctl_c[0]) && $stable(ctl_c[CORDIC_STEPS]) && $stable(fz_c[CORDIC_STEPS]))
		else $error("cell chain moved while output stalled");

	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!turn.valid |-> segs.ready)
		else $error("input not ready with empty output register");

endmodule
